FILE: sv/spca_pkg.sv
package spca_pkg;

  // Field and register widths
  localparam int COST_W     = 8;
  localparam int GRAY_W     = 8;
  localparam int P1_W       = 8;
  localparam int P2_W       = 10;
  localparam int DCNT_W     = 8;
  localparam int DIVISOR_W  = 9;
  localparam int SUM_W      = 11;
  localparam int RES_W      = 12;
  localparam int DISP_OUT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int STEP_CNT_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SMALL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_LARGE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISPARITY_COUNT = 2'd2;

  // Reset values
  localparam logic [P1_W-1:0]   P1_RESET   = 8'd10;
  localparam logic [P2_W-1:0]   P2_RESET   = 10'd150;
  localparam logic [DCNT_W-1:0] DCNT_RESET = 8'd64;
  localparam logic [COST_W-1:0] COST_MAX   = 8'd255;

  // Which neighbor of the previous pixel a read fetches
  typedef enum logic [1:0] {
    RD_LEFT,
    RD_CENTER,
    RD_RIGHT
  } rd_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    calc_best;
    logic    calc_res;
    logic    commit;
    logic    copy_rd;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic d_zero;
    logic div_done;
    logic out_free;
    logic last_disp;
    logic copy_last;
  } dp_sts_t;

endpackage

FILE: sv/spca_ram.sv
module spca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/spca_div.sv
module spca_div
  import spca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [P2_W-1:0]      dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [P2_W-1:0]      quotient_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [P2_W-1:0]       quo_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[P2_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_CNT_W'(P2_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DIVISOR_W'(trial - {1'b0, div_q});
        quo_q <= {quo_q[P2_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DIVISOR_W-1:0];
        quo_q <= {quo_q[P2_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/spca_datapath.sv
module spca_datapath
  import spca_pkg::*;
#(
  parameter int MAX_DISPARITIES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_tdata_i,
  input  logic                  in_tuser_i,
  input  logic                  out_ready_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_tdata_o,
  output logic                  out_tlast_o
);

  localparam int DW = $clog2(MAX_DISPARITIES);
  localparam int CW = $clog2(MAX_DISPARITIES + 1);

  // Configuration
  logic [P1_W-1:0]   p1_q;
  logic [P2_W-1:0]   p2_q;
  logic [DCNT_W-1:0] dcnt_q;

  // Item and pixel state
  logic [COST_W-1:0] cost_q;
  logic [GRAY_W-1:0] gray_q;
  logic              start_q;
  logic [GRAY_W-1:0] prev_gray_q;
  logic [COST_W-1:0] prev_min_q;
  logic [COST_W-1:0] rmin_q;
  logic [P2_W-1:0]   jump_q;
  logic [DW-1:0]     d_q;

  // Neighbors of the previous pixel
  logic [COST_W-1:0] lm_q, lc_q, lp_q;
  logic              rd_pend_q;
  rd_sel_e           rd_sel_q;

  logic [SUM_W-1:0]  best_q;
  logic [COST_W-1:0] res_q;

  // Copy sweep
  logic [DW-1:0] k_q;
  logic          wr_pend_q;
  logic [DW-1:0] wr_addr_q;

  // Output register
  logic                  out_valid_q;
  logic [COST_W-1:0]     out_cost_q;
  logic [DISP_OUT_W-1:0] out_disp_q;
  logic                  out_last_q;
  logic [COST_W-1:0]     out_min_q;

  logic [CW-1:0]        n_w;
  logic [DCNT_W:0]      n_full;
  logic                 last_disp;
  logic [GRAY_W-1:0]    absdiff;
  logic [DIVISOR_W-1:0] divisor;
  logic                 div_done;
  logic [P2_W-1:0]      quo;
  logic [DW-1:0]        prev_raddr;
  logic [COST_W-1:0]    prev_rdata;
  logic [COST_W-1:0]    cur_rdata;
  logic [SUM_W-1:0]     cand_m, cand_p, cand_j, best_d;
  logic [SUM_W-1:0]     excess;
  logic [RES_W-1:0]     sum;
  logic [COST_W-1:0]    res_d;
  logic [COST_W-1:0]    rmin_new;

  // Clamp the disparity count to 1..MAX_DISPARITIES
  always_comb begin
    if (dcnt_q == '0) begin
      n_full = (DCNT_W+1)'(1);
    end else if ({1'b0, dcnt_q} > (DCNT_W+1)'(MAX_DISPARITIES)) begin
      n_full = (DCNT_W+1)'(MAX_DISPARITIES);
    end else begin
      n_full = {1'b0, dcnt_q};
    end
  end
  assign n_w       = n_full[CW-1:0];
  assign last_disp = (CW'(d_q) + CW'(1)) >= n_w;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q   <= P1_RESET;
      p2_q   <= P2_RESET;
      dcnt_q <= DCNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PENALTY_SMALL:   p1_q   <= cfg_data_i[P1_W-1:0];
        REG_PENALTY_LARGE:   p2_q   <= cfg_data_i[P2_W-1:0];
        REG_DISPARITY_COUNT: dcnt_q <= cfg_data_i[DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cost_q  <= in_tdata_i[COST_W-1:0];
      gray_q  <= in_tdata_i[COST_W +: GRAY_W];
      start_q <= in_tuser_i;
    end
  end

  // Jump penalty divisor from the gray change
  assign absdiff = (gray_q > prev_gray_q) ? gray_q - prev_gray_q : prev_gray_q - gray_q;
  assign divisor = {1'b0, absdiff} + DIVISOR_W'(1);

  spca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (p2_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Previous pixel costs
  always_comb begin
    case (cmd_i.rd_sel)
      RD_LEFT:  prev_raddr = d_q - DW'(1);
      RD_RIGHT: prev_raddr = d_q + DW'(1);
      default:  prev_raddr = d_q;
    endcase
  end

  spca_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_DISPARITIES)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (cur_rdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  // Current pixel costs
  spca_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_DISPARITIES)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (d_q),
    .wdata_i (res_q),
    .re_i    (cmd_i.copy_rd),
    .raddr_i (k_q),
    .rdata_o (cur_rdata)
  );

  // Steer returning read data into the neighbor registers
  always_ff @(posedge clk_i) begin
    rd_sel_q <= cmd_i.rd_sel;
    if (rd_pend_q) begin
      case (rd_sel_q)
        RD_LEFT:  lm_q <= prev_rdata;
        RD_RIGHT: lp_q <= prev_rdata;
        default:  lc_q <= prev_rdata;
      endcase
    end
  end

  // Least candidate, excluding neighbors outside the range
  assign cand_m = {3'b0, lm_q} + {3'b0, p1_q};
  assign cand_p = {3'b0, lp_q} + {3'b0, p1_q};
  assign cand_j = {3'b0, prev_min_q} + {1'b0, jump_q};
  always_comb begin
    best_d = {3'b0, lc_q};
    if ((d_q != '0) && (cand_m < best_d)) begin
      best_d = cand_m;
    end
    if (!last_disp && (cand_p < best_d)) begin
      best_d = cand_p;
    end
    if (cand_j < best_d) begin
      best_d = cand_j;
    end
  end

  // Add the excess over the previous minimum and saturate; at a path start pass the cost through
  assign excess = (best_q > {3'b0, prev_min_q}) ? best_q - {3'b0, prev_min_q} : '0;
  assign sum    = {4'b0, cost_q} + {1'b0, excess};
  always_comb begin
    if (start_q) begin
      res_d = cost_q;
    end else if (sum > RES_W'(COST_MAX)) begin
      res_d = COST_MAX;
    end else begin
      res_d = sum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_best) begin
      best_q <= best_d;
    end
    if (cmd_i.calc_res) begin
      res_q <= res_d;
    end
  end

  assign rmin_new = (res_q < rmin_q) ? res_q : rmin_q;

  // Pixel state, copy sweep and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_gray_q <= '0;
      prev_min_q  <= COST_MAX;
      rmin_q      <= COST_MAX;
      jump_q      <= '0;
      d_q         <= '0;
      rd_pend_q   <= 1'b0;
      k_q         <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      wr_pend_q <= cmd_i.copy_rd;
      if (div_done) begin
        jump_q <= (quo > {2'b0, p1_q}) ? quo : {2'b0, p1_q};
      end
      if (cmd_i.copy_rd) begin
        k_q <= k_q + DW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        k_q         <= '0;
        if (last_disp) begin
          prev_min_q  <= rmin_new;
          rmin_q      <= COST_MAX;
          prev_gray_q <= gray_q;
          d_q         <= '0;
        end else begin
          rmin_q <= rmin_new;
          d_q    <= d_q + DW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload and copy write address
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_rd) begin
      wr_addr_q <= k_q;
    end
    if (cmd_i.commit) begin
      out_cost_q <= res_q;
      out_disp_q <= DISP_OUT_W'(d_q);
      out_last_q <= last_disp;
      out_min_q  <= last_disp ? rmin_new : '0;
    end
  end

  assign sts_o.d_zero    = (d_q == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_disp = last_disp;
  assign sts_o.copy_last = (CW'(k_q) + CW'(1)) == n_w;

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {1'b0, out_min_q, out_disp_q, out_cost_q};
  assign out_tlast_o = out_last_q;

endmodule

FILE: sv/spca_ctrl.sv
module spca_ctrl
  import spca_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    in_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RD_LEFT,
    S_RD_CENTER,
    S_RD_RIGHT,
    S_RD_WAIT,
    S_BEST,
    S_RES,
    S_OUT,
    S_COPY,
    S_COPY_END
  } state_e;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through one item, then the copy sweep at pixel end
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CENTER;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.d_zero ? S_DIV_GO : S_RD_LEFT;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_RD_LEFT;
        end
      end
      S_RD_LEFT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LEFT;
        state_d      = S_RD_CENTER;
      end
      S_RD_CENTER: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CENTER;
        state_d      = S_RD_RIGHT;
      end
      S_RD_RIGHT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RIGHT;
        state_d      = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        state_d = S_BEST;
      end
      S_BEST: begin
        cmd_o.calc_best = 1'b1;
        state_d         = S_RES;
      end
      S_RES: begin
        cmd_o.calc_res = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.last_disp ? S_COPY : S_IDLE;
        end
      end
      S_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_COPY_END;
        end
      end
      S_COPY_END: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/sgm_path_cost_aggregation.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: match_cost, pixel_gray; tuser: path_start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: aggr_cost, disp_index, pixel_min;
//                                             tlast: pixel_done
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One item at a time: each disparity takes three reads through the single read port of the
// previous-cost memory, then the compare and saturate steps.
// Disparity 0 also runs the bit-serial jump penalty divider first.
// The last disparity of a pixel then copies the pixel's D costs into the previous-cost
// memory, one entry a cycle (D = clamped disparity count).
// No clearing pass after reset; a waiting result holds the next item in its output step.
module sgm_path_cost_aggregation
  import spca_pkg::*;
#(
  parameter int MAX_DISPARITIES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] match_cost, [15:8] pixel_gray
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] path_start
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] aggr_cost, [14:8] disp_index, [22:15] pixel_min, [23] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  spca_datapath #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata),
    .out_tlast_o (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // One item in flight: no second transfer right after an accepted one
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A result is committed only into a free output register
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending result");

  // The divider runs only on a pixel's first disparity
  a_div_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> sts.d_zero)
    else $error("jump penalty recomputed mid-pixel");

  // The pixel minimum is zero except on the last disparity
  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[22:15] == 8'd0)
    else $error("pixel minimum shown before the last disparity");
`endif

endmodule
